// ===== hw/rtl/zor_pkg.sv =====
// ----------------------------------------------------------------------------
// zor_pkg
// Shared types, sizes and codes of the zonotope order reduction unit.
// ----------------------------------------------------------------------------
package zor_pkg;

  localparam int STATE_DIM = 6;
  localparam int MAX_GEN   = 64;
  localparam int ELEM_W    = 32;
  localparam int GIDX_W    = $clog2(MAX_GEN);       // generator address bits
  localparam int CNT_W     = $clog2(MAX_GEN + 1);   // column count bits
  localparam int DIM_W     = $clog2(STATE_DIM);     // row / weight column bits
  localparam int ACC_W     = 51;                    // six 48-bit terms
  localparam int BOX_W     = 38;                    // 64 x 2^31 magnitude sum

  // status codes of a result beat
  localparam logic [1:0] ST_REDUCED = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_PASSED  = 2'd2;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [STATE_DIM-1:0]    col_t;

  // sort table entry: weighted norm plus original column index
  typedef struct packed {
    logic signed [63:0] q;
    logic [GIDX_W-1:0]  idx;
  } perm_ent_t;

  // control of the norm datapath
  typedef struct packed {
    logic             clr;
    logic             mul_en;
    logic             acc_en;
    logic             qmul_en;
    logic             qacc_en;
    logic [DIM_W-1:0] sel;
  } norm_ctl_t;

  function automatic elem_t sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7FFFFFFF);
    lo = -ACC_W'(64'sh80000000);
    if (v > hi) return 32'sh7FFFFFFF;
    else if (v < lo) return 32'sh80000000;
    else return elem_t'(v[ELEM_W-1:0]);
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    else return s[63:0];
  endfunction

endpackage

// ===== hw/rtl/zor_in_if.sv =====
// ----------------------------------------------------------------------------
// zor_in_if
// Input channel: weight or generator column beats.
// ----------------------------------------------------------------------------
interface zor_in_if;
  logic          valid;
  logic          ready;
  logic          req_type;
  logic [2:0]    weight_column;
  zor_pkg::elem_t elem_0;
  zor_pkg::elem_t elem_1;
  zor_pkg::elem_t elem_2;
  zor_pkg::elem_t elem_3;
  zor_pkg::elem_t elem_4;
  zor_pkg::elem_t elem_5;
  logic          last_column;

  modport source (output valid, req_type, weight_column, elem_0, elem_1, elem_2,
                  elem_3, elem_4, elem_5, last_column, input ready);
  modport sink (input valid, req_type, weight_column, elem_0, elem_1, elem_2,
                elem_3, elem_4, elem_5, last_column, output ready);
endinterface

// ===== hw/rtl/zor_out_if.sv =====
// ----------------------------------------------------------------------------
// zor_out_if
// Result channel: one emitted column per beat.
// ----------------------------------------------------------------------------
interface zor_out_if;
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  zor_pkg::elem_t out_0;
  zor_pkg::elem_t out_1;
  zor_pkg::elem_t out_2;
  zor_pkg::elem_t out_3;
  zor_pkg::elem_t out_4;
  zor_pkg::elem_t out_5;
  logic          last_out;

  modport source (output valid, status, out_0, out_1, out_2, out_3, out_4, out_5,
                  last_out, input ready);
  modport sink (input valid, status, out_0, out_1, out_2, out_3, out_4, out_5,
                last_out, output ready);
endinterface

// ===== hw/rtl/zor_norm.sv =====
// ----------------------------------------------------------------------------
// zor_norm
// Weighted norm datapath: v = W*h one weight column per step with six
// multipliers, then q = sum h_i*v_i with one multiplier and saturation.
// ----------------------------------------------------------------------------
module zor_norm (
  input  logic                clk,
  input  zor_pkg::norm_ctl_t  ctl,
  input  zor_pkg::col_t       wcol,
  input  zor_pkg::col_t       h,
  output logic signed [63:0]  q
);

  logic signed [63:0]                prod_r [zor_pkg::STATE_DIM];
  logic signed [zor_pkg::ACC_W-1:0]  acc_r  [zor_pkg::STATE_DIM];
  logic signed [63:0]                qprod_r;
  logic signed [63:0]                q_r;
  zor_pkg::elem_t                    hsel;
  zor_pkg::elem_t                    vsel;

  assign hsel = h[ctl.sel];
  assign vsel = zor_pkg::sat32(acc_r[ctl.sel]);

  // row products W[i][j]*h[j], then floor shift and accumulate
  always_ff @(posedge clk) begin
    for (int i = 0; i < zor_pkg::STATE_DIM; i++) begin
      if (ctl.mul_en) begin
        prod_r[i] <= 64'(wcol[i]) * 64'(hsel);
      end
      if (ctl.clr) begin
        acc_r[i] <= '0;
      end else if (ctl.acc_en) begin
        acc_r[i] <= acc_r[i] + zor_pkg::ACC_W'(prod_r[i] >>> 16);
      end
    end
  end

  // quadratic form accumulation
  always_ff @(posedge clk) begin
    if (ctl.qmul_en) begin
      qprod_r <= 64'(hsel) * 64'(vsel);
    end
    if (ctl.clr) begin
      q_r <= '0;
    end else if (ctl.qacc_en) begin
      q_r <= zor_pkg::sat_add64(q_r, qprod_r);
    end
  end

  assign q = q_r;

endmodule

// ===== hw/rtl/zonotope_order_reduction_unit.sv =====
// ----------------------------------------------------------------------------
// zonotope_order_reduction_unit
// Stores weight and generator columns, then on the last column computes
// weighted norms, selection-sorts them and emits kept columns plus a box.
// ----------------------------------------------------------------------------
// Load beats are accepted only while idle. A reduction of r columns keeping
// s-6 computes each norm in the shared norm unit, one weight column and then
// one row per step, runs sort pass j over positions j to r-1, and reads each
// kept or summed column through the single read port of the column memory;
// the box goes out one row per beat. A target of 6 or less gives one invalid
// beat; a target of at least r passes the columns through. Reset clears the
// column count, the sequencer and the output valid flag, and sets tgt_r to 12.
module zonotope_order_reduction_unit (
  input  logic              clk,
  input  logic              rst_n,
  zor_in_if.sink            in_bus,
  zor_out_if.source         out_bus,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_NRD   = 5'd1;
  localparam logic [4:0] S_NMUL  = 5'd2;
  localparam logic [4:0] S_NACC  = 5'd3;
  localparam logic [4:0] S_NQM   = 5'd4;
  localparam logic [4:0] S_NQA   = 5'd5;
  localparam logic [4:0] S_NWR   = 5'd6;
  localparam logic [4:0] S_SINIT = 5'd7;
  localparam logic [4:0] S_SSCAN = 5'd8;
  localparam logic [4:0] S_SWP1  = 5'd9;
  localparam logic [4:0] S_SWP2  = 5'd10;
  localparam logic [4:0] S_E1    = 5'd11;
  localparam logic [4:0] S_E2    = 5'd12;
  localparam logic [4:0] S_E3    = 5'd13;
  localparam logic [4:0] S_B1    = 5'd14;
  localparam logic [4:0] S_B2    = 5'd15;
  localparam logic [4:0] S_B3    = 5'd16;
  localparam logic [4:0] S_BOUT  = 5'd17;
  localparam logic [4:0] S_P1    = 5'd18;
  localparam logic [4:0] S_P2    = 5'd19;
  localparam logic [4:0] S_INV   = 5'd20;

  localparam logic [zor_pkg::DIM_W-1:0] LAST_ROW = zor_pkg::DIM_W'(zor_pkg::STATE_DIM - 1);

  // memories
  zor_pkg::col_t      gen_mem  [zor_pkg::MAX_GEN];
  zor_pkg::col_t      wt_mem   [zor_pkg::STATE_DIM];
  zor_pkg::perm_ent_t perm_mem [zor_pkg::MAX_GEN];
  zor_pkg::col_t      gen_q;
  zor_pkg::col_t      wt_q;
  zor_pkg::perm_ent_t perm_q;

  logic                          gen_we, gen_re, wt_we, wt_re, perm_we, perm_re;
  logic [zor_pkg::GIDX_W-1:0]    gen_waddr, gen_raddr, perm_waddr, perm_raddr;
  logic [zor_pkg::DIM_W-1:0]     wt_waddr, wt_raddr;
  zor_pkg::perm_ent_t            perm_wdata;

  // control state
  logic [4:0]                    state_r, state_nxt;
  logic [zor_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [zor_pkg::CNT_W-1:0]     r_r, r_nxt;
  logic [zor_pkg::CNT_W-1:0]     k_r, k_nxt;
  logic [zor_pkg::CNT_W-1:0]     j_r, j_nxt;
  logic [zor_pkg::DIM_W-1:0]     sel_r, sel_nxt;
  logic [6:0]                    tgt_r;
  logic [zor_pkg::CNT_W-1:0]     keep;

  // sort registers
  logic signed [63:0]            best_q_r;
  logic [zor_pkg::GIDX_W-1:0]    best_idx_r;
  logic [zor_pkg::CNT_W-1:0]     best_pos_r;
  zor_pkg::perm_ent_t            jent_r;

  // box sums
  logic [zor_pkg::BOX_W-1:0]     box_r [zor_pkg::STATE_DIM];
  logic                          box_clr, box_acc;

  // output register
  logic                          out_v_r;
  logic [1:0]                    ost_r;
  zor_pkg::col_t                 ocol_r;
  logic                          olast_r;
  logic                          out_free, out_load;
  logic [1:0]                    ld_st;
  zor_pkg::col_t                 ld_col;
  logic                          ld_last;

  logic                          in_acc;
  zor_pkg::col_t                 in_col;
  zor_pkg::norm_ctl_t            nctl;
  logic signed [63:0]            norm_q;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid & in_bus.ready;
  assign in_col       = {in_bus.elem_5, in_bus.elem_4, in_bus.elem_3,
                         in_bus.elem_2, in_bus.elem_1, in_bus.elem_0};
  assign keep         = zor_pkg::CNT_W'(tgt_r) - zor_pkg::CNT_W'(zor_pkg::STATE_DIM);
  assign out_free     = !out_v_r || out_bus.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= 7'd12;
    end else if (cfg_we) begin
      tgt_r <= cfg_wdata;
    end
  end

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (gen_we)  gen_mem[gen_waddr]   <= in_col;
    if (gen_re)  gen_q                <= gen_mem[gen_raddr];
    if (wt_we)   wt_mem[wt_waddr]     <= in_col;
    if (wt_re)   wt_q                 <= wt_mem[wt_raddr];
    if (perm_we) perm_mem[perm_waddr] <= perm_wdata;
    if (perm_re) perm_q               <= perm_mem[perm_raddr];
  end

  assign gen_we    = in_acc && in_bus.req_type && !count_r[zor_pkg::CNT_W-1];
  assign gen_waddr = count_r[zor_pkg::GIDX_W-1:0];
  assign wt_we     = in_acc && !in_bus.req_type &&
                     (in_bus.weight_column < 3'(zor_pkg::STATE_DIM));
  assign wt_waddr  = in_bus.weight_column[zor_pkg::DIM_W-1:0];

  zor_norm u_norm (
    .clk  (clk),
    .ctl  (nctl),
    .wcol (wt_q),
    .h    (gen_q),
    .q    (norm_q)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    r_nxt      = r_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    sel_nxt    = sel_r;
    gen_re     = 1'b0;
    gen_raddr  = k_r[zor_pkg::GIDX_W-1:0];
    wt_re      = 1'b0;
    wt_raddr   = '0;
    perm_re    = 1'b0;
    perm_raddr = k_r[zor_pkg::GIDX_W-1:0];
    perm_we    = 1'b0;
    perm_waddr = k_r[zor_pkg::GIDX_W-1:0];
    perm_wdata = '{q: norm_q, idx: k_r[zor_pkg::GIDX_W-1:0]};
    nctl       = '{clr: 1'b0, mul_en: 1'b0, acc_en: 1'b0, qmul_en: 1'b0,
                   qacc_en: 1'b0, sel: sel_r};
    box_clr    = 1'b0;
    box_acc    = 1'b0;
    out_load   = 1'b0;
    ld_st      = zor_pkg::ST_REDUCED;
    ld_col     = gen_q;
    ld_last    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_bus.req_type) begin
          r_nxt = count_r + zor_pkg::CNT_W'(!count_r[zor_pkg::CNT_W-1]);
          count_nxt = r_nxt;
          if (in_bus.last_column) begin
            count_nxt = '0;
            k_nxt     = '0;
            sel_nxt   = '0;
            if (tgt_r <= 7'(zor_pkg::STATE_DIM)) begin
              state_nxt = S_INV;
            end else if (zor_pkg::CNT_W'(tgt_r) >= r_nxt) begin
              state_nxt = S_P1;
            end else begin
              state_nxt = S_NRD;
            end
          end
        end
      end
      // norm of column k
      S_NRD: begin
        gen_re    = 1'b1;
        wt_re     = 1'b1;
        nctl.clr  = 1'b1;
        sel_nxt   = '0;
        state_nxt = S_NMUL;
      end
      S_NMUL: begin
        nctl.mul_en = 1'b1;
        state_nxt   = S_NACC;
      end
      S_NACC: begin
        nctl.acc_en = 1'b1;
        if (sel_r == LAST_ROW) begin
          sel_nxt   = '0;
          state_nxt = S_NQM;
        end else begin
          wt_re     = 1'b1;
          wt_raddr  = sel_r + 1'b1;
          sel_nxt   = sel_r + 1'b1;
          state_nxt = S_NMUL;
        end
      end
      S_NQM: begin
        nctl.qmul_en = 1'b1;
        state_nxt    = S_NQA;
      end
      S_NQA: begin
        nctl.qacc_en = 1'b1;
        if (sel_r == LAST_ROW) begin
          state_nxt = S_NWR;
        end else begin
          sel_nxt   = sel_r + 1'b1;
          state_nxt = S_NQM;
        end
      end
      S_NWR: begin
        perm_we = 1'b1;
        k_nxt   = k_r + 1'b1;
        if (k_nxt == r_r) begin
          j_nxt     = '0;
          state_nxt = S_SINIT;
        end else begin
          state_nxt = S_NRD;
        end
      end
      // selection sort pass j
      S_SINIT: begin
        perm_re    = 1'b1;
        perm_raddr = j_r[zor_pkg::GIDX_W-1:0];
        k_nxt      = j_r;
        state_nxt  = S_SSCAN;
      end
      S_SSCAN: begin
        if (k_r == r_r - 1'b1) begin
          state_nxt = S_SWP1;
        end else begin
          perm_re    = 1'b1;
          perm_raddr = k_r[zor_pkg::GIDX_W-1:0] + 1'b1;
          k_nxt      = k_r + 1'b1;
        end
      end
      S_SWP1: begin
        perm_we    = 1'b1;
        perm_waddr = j_r[zor_pkg::GIDX_W-1:0];
        perm_wdata = '{q: best_q_r, idx: best_idx_r};
        state_nxt  = S_SWP2;
      end
      S_SWP2: begin
        perm_we    = 1'b1;
        perm_waddr = best_pos_r[zor_pkg::GIDX_W-1:0];
        perm_wdata = jent_r;
        j_nxt      = j_r + 1'b1;
        if (j_nxt == keep) begin
          k_nxt     = '0;
          box_clr   = 1'b1;
          state_nxt = S_E1;
        end else begin
          state_nxt = S_SINIT;
        end
      end
      // kept columns in sorted order
      S_E1: begin
        perm_re   = 1'b1;
        state_nxt = S_E2;
      end
      S_E2: begin
        gen_re    = 1'b1;
        gen_raddr = perm_q.idx;
        state_nxt = S_E3;
      end
      S_E3: begin
        if (out_free) begin
          out_load = 1'b1;
          k_nxt    = k_r + 1'b1;
          state_nxt = (k_nxt == keep) ? S_B1 : S_E1;
        end
      end
      // box sums over the remaining columns
      S_B1: begin
        perm_re   = 1'b1;
        state_nxt = S_B2;
      end
      S_B2: begin
        gen_re    = 1'b1;
        gen_raddr = perm_q.idx;
        state_nxt = S_B3;
      end
      S_B3: begin
        box_acc = 1'b1;
        k_nxt   = k_r + 1'b1;
        if (k_nxt == r_r) begin
          sel_nxt   = '0;
          state_nxt = S_BOUT;
        end else begin
          state_nxt = S_B1;
        end
      end
      S_BOUT: begin
        ld_col = '0;
        ld_col[sel_r] = (box_r[sel_r] > zor_pkg::BOX_W'(32'h7FFFFFFF)) ?
                        32'sh7FFFFFFF : zor_pkg::elem_t'(box_r[sel_r][31:0]);
        ld_last = (sel_r == LAST_ROW);
        if (out_free) begin
          out_load = 1'b1;
          sel_nxt  = sel_r + 1'b1;
          if (sel_r == LAST_ROW) state_nxt = S_IDLE;
        end
      end
      // pass-through in load order
      S_P1: begin
        gen_re    = 1'b1;
        state_nxt = S_P2;
      end
      S_P2: begin
        ld_st   = zor_pkg::ST_PASSED;
        ld_last = (k_r == r_r - 1'b1);
        if (out_free) begin
          out_load  = 1'b1;
          k_nxt     = k_r + 1'b1;
          state_nxt = ld_last ? S_IDLE : S_P1;
        end
      end
      S_INV: begin
        ld_st   = zor_pkg::ST_INVALID;
        ld_col  = '0;
        ld_last = 1'b1;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    k_r   <= k_nxt;
    j_r   <= j_nxt;
    sel_r <= sel_nxt;
  end

  // running maximum of the sort pass; earliest maximum wins
  always_ff @(posedge clk) begin
    if (state_r == S_SSCAN) begin
      if (k_r == j_r) begin
        jent_r     <= perm_q;
        best_q_r   <= perm_q.q;
        best_idx_r <= perm_q.idx;
        best_pos_r <= k_r;
      end else if (perm_q.q > best_q_r) begin
        best_q_r   <= perm_q.q;
        best_idx_r <= perm_q.idx;
        best_pos_r <= k_r;
      end
    end
  end

  // absolute value sums per row
  always_ff @(posedge clk) begin
    for (int i = 0; i < zor_pkg::STATE_DIM; i++) begin
      if (box_clr) begin
        box_r[i] <= '0;
      end else if (box_acc) begin
        box_r[i] <= box_r[i] + (gen_q[i][31] ? -zor_pkg::BOX_W'(gen_q[i])
                                             : zor_pkg::BOX_W'(gen_q[i]));
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      ost_r   <= ld_st;
      ocol_r  <= ld_col;
      olast_r <= ld_last;
    end
  end

  assign out_bus.valid    = out_v_r;
  assign out_bus.status   = ost_r;
  assign out_bus.out_0    = ocol_r[0];
  assign out_bus.out_1    = ocol_r[1];
  assign out_bus.out_2    = ocol_r[2];
  assign out_bus.out_3    = ocol_r[3];
  assign out_bus.out_4    = ocol_r[4];
  assign out_bus.out_5    = ocol_r[5];
  assign out_bus.last_out = olast_r;

endmodule
